FILE: hw/rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types, constants and helpers of the LCD scanline timing controller.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam logic [10:0] LINE_CYCLES   = 11'd1006;
    localparam logic [10:0] HBLANK_CYCLES = 11'd226;
    localparam logic [7:0]  VISIBLE_LINES = 8'd160;
    localparam logic [7:0]  LAST_LINE     = 8'd227;
    localparam logic [7:0]  CAPTURE_FIRST = 8'd2;
    localparam logic [7:0]  CAPTURE_END   = VISIBLE_LINES + 8'd2;

    localparam int CFG_DATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int REF_W      = 28;
    localparam int OUT_DATA_W = 144;

    localparam logic [31:0] STEPS_RESET = 32'h0100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VMATCH  = 3'd0,
        CFG_IRQEN   = 3'd1,
        CFG_MOSEN   = 3'd2,
        CFG_HEIGHTS = 3'd3,
        CFG_STEPS0  = 3'd4,
        CFG_STEPS1  = 3'd5,
        CFG_ORIGIN0 = 3'd6,
        CFG_ORIGIN1 = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_LINE    = 4'b0001,
        PH_HBLANK  = 4'b0010,
        PH_VLINE   = 4'b0100,
        PH_VHBLANK = 4'b1000
    } phase_t;

    localparam logic [1:0] CODE_LINE    = 2'd0;
    localparam logic [1:0] CODE_HBLANK  = 2'd1;
    localparam logic [1:0] CODE_VLINE   = 2'd2;
    localparam logic [1:0] CODE_VHBLANK = 2'd3;

    typedef struct packed {
        logic [7:0]  vcount_match;
        logic [2:0]  irq_enables;
        logic [1:0]  mosaic_enables;
        logic [7:0]  mosaic_heights;
        logic [31:0] steps0;
        logic [31:0] steps1;
        logic [55:0] origin0;
        logic [55:0] origin1;
    } cfg_t;

    typedef struct packed {
        logic signed [REF_W-1:0] layer1_y;
        logic signed [REF_W-1:0] layer1_x;
        logic signed [REF_W-1:0] layer0_y;
        logic signed [REF_W-1:0] layer0_x;
        logic                    frame_done;
        logic                    render_line;
        logic [2:0]              dma_request;
        logic [2:0]              irq_raise;
        logic [2:0]              status_flags;
        logic [7:0]              line_number;
        logic [10:0]             wait_cycles;
        logic [1:0]              next_phase;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t p);
        logic [1:0] c;
        unique case (p)
            PH_LINE:    c = CODE_LINE;
            PH_HBLANK:  c = CODE_HBLANK;
            PH_VLINE:   c = CODE_VLINE;
            PH_VHBLANK: c = CODE_VHBLANK;
            default:    c = CODE_LINE;
        endcase
        return c;
    endfunction

    function automatic logic [REF_W-1:0] sext_step(input logic [15:0] v);
        return {{(REF_W-16){v[15]}}, v};
    endfunction

endpackage

FILE: hw/rtl/lst_cfg_regs.sv
// ----------------------------------------------------------------------------
// lst_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lst_cfg_regs import lst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VMATCH:  cfg_next.vcount_match   = cfg_wr_data[7:0];
                CFG_IRQEN:   cfg_next.irq_enables    = cfg_wr_data[2:0];
                CFG_MOSEN:   cfg_next.mosaic_enables = cfg_wr_data[1:0];
                CFG_HEIGHTS: cfg_next.mosaic_heights = cfg_wr_data[7:0];
                CFG_STEPS0:  cfg_next.steps0         = cfg_wr_data[31:0];
                CFG_STEPS1:  cfg_next.steps1         = cfg_wr_data[31:0];
                CFG_ORIGIN0: cfg_next.origin0        = cfg_wr_data;
                CFG_ORIGIN1: cfg_next.origin1        = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{vcount_match:   8'd0,
                         irq_enables:    3'd0,
                         mosaic_enables: 2'd0,
                         mosaic_heights: 8'd0,
                         steps0:         STEPS_RESET,
                         steps1:         STEPS_RESET,
                         origin0:        56'd0,
                         origin1:        56'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/lst_core.sv
// ----------------------------------------------------------------------------
// lst_core
// Phase sequencer: line counter, flags, mosaic rows and affine references.
// Produces the result of one item from the updated state.
// ----------------------------------------------------------------------------
module lst_core import lst_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    phase_end,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t           phase_reg, phase_next;
    logic [7:0]       line_reg, line_next;
    logic [2:0]       flags_reg, flags_next;
    logic [3:0]       bg_row_reg, bg_row_next;
    logic [3:0]       obj_row_reg, obj_row_next;
    logic [REF_W-1:0] ref_x_reg [2];
    logic [REF_W-1:0] ref_y_reg [2];
    logic [REF_W-1:0] ref_x_next [2];
    logic [REF_W-1:0] ref_y_next [2];

    logic [2:0]       irq, dma;
    logic             render, frame;
    logic [7:0]       line_inc;
    logic [4:0]       bg_h, obj_h;
    logic [4:0]       bg_row_inc, obj_row_inc;
    logic [31:0]      steps [2];
    logic [55:0]      origin [2];
    logic [REF_W-1:0] pb [2];
    logic [REF_W-1:0] pd [2];
    logic [REF_W-1:0] pb_blk [2];
    logic [REF_W-1:0] pd_blk [2];

    assign steps[0]  = cfg.steps0;
    assign steps[1]  = cfg.steps1;
    assign origin[0] = cfg.origin0;
    assign origin[1] = cfg.origin1;

    assign line_inc    = line_reg + 8'd1;
    assign bg_h        = {1'b0, cfg.mosaic_heights[3:0]} + 5'd1;
    assign obj_h       = {1'b0, cfg.mosaic_heights[7:4]} + 5'd1;
    assign bg_row_inc  = {1'b0, bg_row_reg} + 5'd1;
    assign obj_row_inc = {1'b0, obj_row_reg} + 5'd1;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            pb[i]     = sext_step(steps[i][15:0]);
            pd[i]     = sext_step(steps[i][31:16]);
            pb_blk[i] = REF_W'(pb[i] * {{(REF_W-5){1'b0}}, bg_h});
            pd_blk[i] = REF_W'(pd[i] * {{(REF_W-5){1'b0}}, bg_h});
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        line_next    = line_reg;
        flags_next   = flags_reg;
        bg_row_next  = bg_row_reg;
        obj_row_next = obj_row_reg;
        ref_x_next   = ref_x_reg;
        ref_y_next   = ref_y_reg;
        irq          = '0;
        dma          = '0;
        render       = 1'b0;
        frame        = 1'b0;
        if (phase_end) begin
            unique case (phase_reg)
                PH_LINE: begin
                    phase_next    = PH_HBLANK;
                    flags_next[1] = 1'b1;
                    dma[0]        = 1'b1;
                    dma[2]        = line_reg >= CAPTURE_FIRST;
                    irq[0]        = cfg.irq_enables[0];
                end
                PH_HBLANK: begin
                    flags_next[1] = 1'b0;
                    line_next     = line_inc;
                    flags_next[2] = line_inc == cfg.vcount_match;
                    if (line_inc == VISIBLE_LINES) begin
                        frame         = 1'b1;
                        phase_next    = PH_VLINE;
                        dma[1]        = 1'b1;
                        flags_next[0] = 1'b1;
                        irq[1]        = cfg.irq_enables[1];
                        bg_row_next   = '0;
                        obj_row_next  = '0;
                        for (int i = 0; i < 2; i++) begin
                            ref_x_next[i] = origin[i][27:0];
                            ref_y_next[i] = origin[i][55:28];
                        end
                    end else begin
                        bg_row_next  = (bg_row_inc == bg_h) ? 4'd0 : bg_row_inc[3:0];
                        obj_row_next = (obj_row_inc == obj_h) ? 4'd0 : obj_row_inc[3:0];
                        for (int i = 0; i < 2; i++) begin
                            if (cfg.mosaic_enables[i]) begin
                                if (bg_row_next == 4'd0) begin
                                    ref_x_next[i] = ref_x_reg[i] + pb_blk[i];
                                    ref_y_next[i] = ref_y_reg[i] + pd_blk[i];
                                end
                            end else begin
                                ref_x_next[i] = ref_x_reg[i] + pb[i];
                                ref_y_next[i] = ref_y_reg[i] + pd[i];
                            end
                        end
                        phase_next = PH_LINE;
                        render     = 1'b1;
                    end
                    irq[2] = flags_next[2] && cfg.irq_enables[2];
                end
                PH_VLINE: begin
                    phase_next    = PH_VHBLANK;
                    flags_next[1] = 1'b1;
                    dma[2]        = line_reg < CAPTURE_END;
                    irq[0]        = cfg.irq_enables[0];
                end
                PH_VHBLANK: begin
                    flags_next[1] = 1'b0;
                    if (line_reg == LAST_LINE) begin
                        line_next     = '0;
                        flags_next[2] = cfg.vcount_match == 8'd0;
                        phase_next    = PH_LINE;
                        render        = 1'b1;
                    end else begin
                        phase_next = PH_VLINE;
                        if (line_reg == LAST_LINE - 8'd1) begin
                            flags_next[0] = 1'b0;
                        end
                        line_next     = line_inc;
                        flags_next[2] = line_inc == cfg.vcount_match;
                    end
                    irq[2] = flags_next[2] && cfg.irq_enables[2];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LINE;
            line_reg    <= '0;
            flags_reg   <= '0;
            bg_row_reg  <= '0;
            obj_row_reg <= '0;
            for (int i = 0; i < 2; i++) begin
                ref_x_reg[i] <= '0;
                ref_y_reg[i] <= '0;
            end
        end else if (step) begin
            phase_reg   <= phase_next;
            line_reg    <= line_next;
            flags_reg   <= flags_next;
            bg_row_reg  <= bg_row_next;
            obj_row_reg <= obj_row_next;
            ref_x_reg   <= ref_x_next;
            ref_y_reg   <= ref_y_next;
        end
    end

    always_comb begin
        result.next_phase   = phase_code(phase_next);
        result.wait_cycles  = (phase_next == PH_HBLANK || phase_next == PH_VHBLANK)
                              ? HBLANK_CYCLES : LINE_CYCLES;
        result.line_number  = line_next;
        result.status_flags = flags_next;
        result.irq_raise    = irq;
        result.dma_request  = dma;
        result.render_line  = render;
        result.frame_done   = frame;
        result.layer0_x     = ref_x_next[0];
        result.layer0_y     = ref_y_next[0];
        result.layer1_x     = ref_x_next[1];
        result.layer1_y     = ref_y_next[1];
    end

endmodule

FILE: hw/rtl/lcd_scanline_timing_controller.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller
// Steps the LCD display phases and reports timing, flags, pulses and affine
// reference points for each item.
//
//  channel   direction  tdata (low bit up)
//  s_axis    in         phase_end[0], zero pad to 8 bits
//  m_axis    out        next_phase, wait_cycles, line_number, status_flags,
//                       irq_raise, dma_request, render_line, frame_done,
//                       layer0_x, layer0_y, layer1_x, layer1_y (144 bits)
//  cfg       in         write only, index 0..7, 56-bit data
//
// One item per cycle sustained unless the output stalls; an item passes the
// input register, then the phase update and result register.
// aresetn clears phase, counters, flags, references; resets config registers.
// A stalled result holds in the output register; the input register keeps
// accepting while the output register is free or being drained.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller import lst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // phase_end[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // see table above
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic                  in_valid_reg;
    logic                  phase_end_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  advance;
    logic                  step;
    cfg_t                  cfg;
    result_t               result;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    lst_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lst_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .phase_end (phase_end_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            phase_end_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/lst_checker.sv
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks of the LCD scanline timing controller.
// ----------------------------------------------------------------------------
module lst_checker import lst_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[12:2] == HBLANK_CYCLES)
                                 : (m_tdata[12:2] == LINE_CYCLES)))
        else $error("phase length does not match phase");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31] |-> m_tdata[1:0] == CODE_VLINE
                                 && m_tdata[20:13] == VISIBLE_LINES && m_tdata[21])
        else $error("frame done outside vblank entry");

    a_render: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |-> m_tdata[1:0] == CODE_LINE && !m_tdata[22])
        else $error("render request outside a visible line");

endmodule

bind lcd_scanline_timing_controller lst_checker u_lst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/lst_timing_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Scanline timing scoreboard
// Predicts the phase, counter, flag, pulse and affine reference results for
// each accepted phase-end item and checks the block's results field by field,
// in order.
// ----------------------------------------------------------------------------
package lst_timing_scoreboard_pkg;
    import lst_pkg::*;

    class timing_scoreboard;
        logic [7:0]       vmatch;
        logic [2:0]       irq_en;
        logic [1:0]       mosaic_en;
        logic [7:0]       heights;
        logic [31:0]      steps [2];
        logic [55:0]      origin [2];

        logic [1:0]       phase;
        logic [7:0]       line;
        logic [2:0]       flags;
        logic [3:0]       bg_row;
        logic [3:0]       sprite_row;
        logic [REF_W-1:0] ref_x [2];
        logic [REF_W-1:0] ref_y [2];

        result_t          pending_results [$];
        int               failures;

        function new();
            vmatch     = '0;
            irq_en     = '0;
            mosaic_en  = '0;
            heights    = '0;
            steps[0]   = STEPS_RESET;
            steps[1]   = STEPS_RESET;
            origin[0]  = '0;
            origin[1]  = '0;
            phase      = CODE_LINE;
            line       = '0;
            flags      = '0;
            bg_row     = '0;
            sprite_row = '0;
            ref_x[0]   = '0;
            ref_x[1]   = '0;
            ref_y[0]   = '0;
            ref_y[1]   = '0;
            failures   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_VMATCH:  vmatch    = v[7:0];
                CFG_IRQEN:   irq_en    = v[2:0];
                CFG_MOSEN:   mosaic_en = v[1:0];
                CFG_HEIGHTS: heights   = v[7:0];
                CFG_STEPS0:  steps[0]  = v[31:0];
                CFG_STEPS1:  steps[1]  = v[31:0];
                CFG_ORIGIN0: origin[0] = v;
                CFG_ORIGIN1: origin[1] = v;
                default: ;
            endcase
        endfunction

        function logic [3:0] next_row(logic [3:0] row, logic [4:0] height);
            logic [4:0] n;
            n = {1'b0, row} + 5'd1;
            return (n == height) ? 4'd0 : n[3:0];
        endfunction

        function void note_phase_end(bit pe);
            result_t          r;
            logic [2:0]       irq;
            logic [2:0]       dma;
            logic             render;
            logic             frame;
            logic [REF_W-1:0] bgh;
            logic [REF_W-1:0] obh;
            logic [REF_W-1:0] pb;
            logic [REF_W-1:0] pd;
            irq    = '0;
            dma    = '0;
            render = 1'b0;
            frame  = 1'b0;
            if (pe) begin
                case (phase)
                    CODE_LINE: begin
                        phase    = CODE_HBLANK;
                        flags[1] = 1'b1;
                        dma[0]   = 1'b1;
                        if (line >= CAPTURE_FIRST) dma[2] = 1'b1;
                        if (irq_en[0]) irq[0] = 1'b1;
                    end
                    CODE_HBLANK: begin
                        flags[1] = 1'b0;
                        line     = line + 8'd1;
                        flags[2] = (line == vmatch);
                        if (line == VISIBLE_LINES) begin
                            frame      = 1'b1;
                            phase      = CODE_VLINE;
                            dma[1]     = 1'b1;
                            flags[0]   = 1'b1;
                            if (irq_en[1]) irq[1] = 1'b1;
                            bg_row     = '0;
                            sprite_row = '0;
                            for (int i = 0; i < 2; i++) begin
                                ref_x[i] = origin[i][27:0];
                                ref_y[i] = origin[i][55:28];
                            end
                        end else begin
                            bgh        = {24'd0, heights[3:0]} + 28'd1;
                            obh        = {24'd0, heights[7:4]} + 28'd1;
                            bg_row     = next_row(bg_row, bgh[4:0]);
                            sprite_row = next_row(sprite_row, obh[4:0]);
                            for (int i = 0; i < 2; i++) begin
                                pb = {{12{steps[i][15]}}, steps[i][15:0]};
                                pd = {{12{steps[i][31]}}, steps[i][31:16]};
                                if (mosaic_en[i]) begin
                                    if (bg_row == 4'd0) begin
                                        ref_x[i] = ref_x[i] + bgh * pb;
                                        ref_y[i] = ref_y[i] + bgh * pd;
                                    end
                                end else begin
                                    ref_x[i] = ref_x[i] + pb;
                                    ref_y[i] = ref_y[i] + pd;
                                end
                            end
                            phase  = CODE_LINE;
                            render = 1'b1;
                        end
                        if (flags[2] && irq_en[2]) irq[2] = 1'b1;
                    end
                    CODE_VLINE: begin
                        phase    = CODE_VHBLANK;
                        flags[1] = 1'b1;
                        if (line < CAPTURE_END) dma[2] = 1'b1;
                        if (irq_en[0]) irq[0] = 1'b1;
                    end
                    default: begin
                        flags[1] = 1'b0;
                        if (line == LAST_LINE) begin
                            line     = '0;
                            flags[2] = (vmatch == 8'd0);
                            phase    = CODE_LINE;
                            render   = 1'b1;
                        end else begin
                            phase = CODE_VLINE;
                            if (line == LAST_LINE - 8'd1) flags[0] = 1'b0;
                            line     = line + 8'd1;
                            flags[2] = (line == vmatch);
                        end
                        if (flags[2] && irq_en[2]) irq[2] = 1'b1;
                    end
                endcase
            end
            r.next_phase   = phase;
            r.wait_cycles  = phase[0] ? HBLANK_CYCLES : LINE_CYCLES;
            r.line_number  = line;
            r.status_flags = flags;
            r.irq_raise    = irq;
            r.dma_request  = dma;
            r.render_line  = render;
            r.frame_done   = frame;
            r.layer0_x     = ref_x[0];
            r.layer0_y     = ref_y[0];
            r.layer1_x     = ref_x[1];
            r.layer1_y     = ref_y[1];
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            failures++;
        endtask

        task compare(string field, logic [REF_W-1:0] got, logic [REF_W-1:0] want);
            if (got !== want) begin
                report($sformatf("%s got %h want %h", field, got, want));
            end
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data);
            if (pending_results.size() == 0) begin
                report($sformatf("result with no item pending: %h", data));
            end else begin
                want = pending_results.pop_front();
                compare("next_phase", got.next_phase, want.next_phase);
                compare("wait_cycles", got.wait_cycles, want.wait_cycles);
                compare("line_number", got.line_number, want.line_number);
                compare("status_flags", got.status_flags, want.status_flags);
                compare("irq_raise", got.irq_raise, want.irq_raise);
                compare("dma_request", got.dma_request, want.dma_request);
                compare("render_line", got.render_line, want.render_line);
                compare("frame_done", got.frame_done, want.frame_done);
                compare("layer0_x", got.layer0_x, want.layer0_x);
                compare("layer0_y", got.layer0_y, want.layer0_y);
                compare("layer1_x", got.layer1_x, want.layer1_x);
                compare("layer1_y", got.layer1_y, want.layer1_y);
            end
        endtask

        task check_leftovers();
            if (pending_results.size() != 0) begin
                report($sformatf("%0d results never arrived", pending_results.size()));
            end
        endtask
    endclass

endpackage

FILE: sim/lcd_scanline_timing_controller_test.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller_test
// Drives phase-end items through several register settings, from reset values
// through all-ones and all-zeros to random ones, with random idling on both
// channels, and checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lst_pkg::*;
    import lst_timing_scoreboard_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 200;
    localparam int SETTING_COUNT = 6;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               stall_cycles = 0;
    timing_scoreboard sb;

    lcd_scanline_timing_controller i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_phase_end(s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_W-1:0];
    endfunction

    task automatic send_item(input bit pe);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pe};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic apply_setting(input int kind);
        logic [CFG_DATA_W-1:0] v [8];
        for (int i = 0; i < 8; i++) begin
            case (kind)
                0:       v[i] = '1;
                1:       v[i] = '0;
                default: v[i] = rand_word();
            endcase
        end
        if (kind > 1) begin
            case ($urandom_range(0, 3))
                0:       v[CFG_VMATCH][7:0] = 8'd0;
                1:       v[CFG_VMATCH][7:0] = VISIBLE_LINES;
                2:       v[CFG_VMATCH][7:0] = LAST_LINE;
                default: v[CFG_VMATCH][7:0] = 8'($urandom_range(0, 255));
            endcase
        end
        cfg_write(CFG_VMATCH, v[CFG_VMATCH]);
        cfg_write(CFG_IRQEN, v[CFG_IRQEN]);
        cfg_write(CFG_MOSEN, v[CFG_MOSEN]);
        cfg_write(CFG_HEIGHTS, v[CFG_HEIGHTS]);
        cfg_write(CFG_STEPS0, v[CFG_STEPS0]);
        cfg_write(CFG_STEPS1, v[CFG_STEPS1]);
        cfg_write(CFG_ORIGIN0, v[CFG_ORIGIN0]);
        cfg_write(CFG_ORIGIN1, v[CFG_ORIGIN1]);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        bit directed [20] = '{0, 1, 0, 1, 1, 1, 1, 1, 0, 1,
                              1, 1, 1, 1, 1, 1, 0, 1, 1, 1};
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_item(directed[i]);
        drain();

        for (int k = 0; k < SETTING_COUNT; k++) begin
            tx_idle_pct = (k < 2) ? 8 : (k < 4) ? 53 : 0;
            rx_idle_pct = (k < 2) ? 53 : (k < 4) ? 8 : 0;
            apply_setting((k == 0) ? 0 : (k == 2) ? 1 : 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (k == 2 && n == PHASE_ITEMS / 2) drain();
                send_item($urandom_range(0, 9) != 0);
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        sb.check_leftovers();
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
